// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/pcau_pkg.sv
// ----------------------------------------------------------------------------
// pcau_pkg
// types and constants of the phantom clock access and unlock block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcau_pkg;

    localparam int WORD_W  = 64;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int ACT_W   = 2;
    localparam int PADDR_W = 4;

    localparam logic [WORD_W-1:0] PATTERN_RESET = 64'h5CA3_3AC5_5CA3_3AC5;

    localparam int A2_BIT = 2;
    localparam int A0_BIT = 0;

    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

    localparam logic REG_MATCH_PATTERN = 1'b0;

    localparam logic [POS_W-1:0] POS_LAST = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              data_changed;
        logic              clock_unlocked;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/phantom_clock_access_unlock.sv
// ----------------------------------------------------------------------------
// phantom_clock_access_unlock
// phantom clock behind a memory socket: pattern unlock and serial time ring
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      action, address_low, data_in, time_bcd
//  out       output     o_out_valid / i_out_ready    data_out, data_changed, clock_unlocked
//  cfg       input      psel, penable, pwrite        paddr, pwdata, prdata (apb)
//
//  one beat/clock while ready; state updates on accept, result lands in the output register
//  a two-entry output stage (register plus skid) keeps one beat accepted during a stall
//  o_in_ready drops only when both output entries are full
//  synchronous active-low reset; match pattern resets to its default
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phantom_clock_access_unlock (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [pcau_pkg::ACT_W-1:0]           i_action,
    input  wire logic [pcau_pkg::ADDR_W-1:0]          i_address_low,
    input  wire logic [pcau_pkg::DATA_W-1:0]          i_data_in,
    input  wire logic [pcau_pkg::WORD_W-1:0]          i_time_bcd,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [pcau_pkg::DATA_W-1:0]               o_data_out,
    output logic                                      o_data_changed,
    output logic                                      o_clock_unlocked,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pcau_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [pcau_pkg::WORD_W-1:0]          pwdata,
    output logic [pcau_pkg::WORD_W-1:0]               prdata,
    output logic                                      pready
);

    logic [pcau_pkg::WORD_W-1:0] r_pattern;
    logic [pcau_pkg::POS_W-1:0]  r_pat_pos, n_pat_pos;
    logic [pcau_pkg::POS_W-1:0]  r_ring_pos, n_ring_pos;
    logic [pcau_pkg::WORD_W-1:0] r_clock_bits, n_clock_bits;
    logic                        r_unlocked, n_unlocked;
    logic                        r_cmp_en, n_cmp_en;

    logic                        r_out_valid, r_skid_valid;
    pcau_pkg::t_result           r_out, r_skid, n_result;

    logic                        accept_in, out_take, cfg_write;
    logic                        a2, a0, want, clk_bit, drive;
    logic [2*pcau_pkg::WORD_W-1:0] rot_wide;

    assign accept_in = i_in_valid && o_in_ready;
    assign out_take  = r_out_valid && i_out_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign o_in_ready = !r_skid_valid;
    assign pready     = 1'b1;
    assign prdata     = (paddr[3] == pcau_pkg::REG_MATCH_PATTERN) ? r_pattern : '0;

    assign a2       = i_address_low[pcau_pkg::A2_BIT];
    assign a0       = i_address_low[pcau_pkg::A0_BIT];
    assign want     = r_pattern[r_pat_pos];
    assign clk_bit  = r_clock_bits[r_ring_pos];
    assign rot_wide = {i_time_bcd, i_time_bcd} << r_ring_pos;
    assign drive    = (i_action == pcau_pkg::ACT_READ) && a2 && r_unlocked;

    // access decode and state update
    always_comb begin
        n_pat_pos    = r_pat_pos;
        n_ring_pos   = r_ring_pos;
        n_clock_bits = r_clock_bits;
        n_unlocked   = r_unlocked;
        n_cmp_en     = r_cmp_en;
        case (i_action)
            pcau_pkg::ACT_READ, pcau_pkg::ACT_WRITE: begin
                if (a2) begin
                    if (!r_unlocked) begin
                        n_pat_pos = '0;
                        n_cmp_en  = 1'b1;
                    end else begin
                        n_ring_pos = r_ring_pos + 1'b1;
                        if (r_ring_pos == pcau_pkg::POS_LAST) begin
                            n_unlocked = 1'b0;
                        end
                    end
                end else if (r_cmp_en) begin
                    if (!r_unlocked) begin
                        if (want == a0) begin
                            n_pat_pos = r_pat_pos + 1'b1;
                            if (r_pat_pos == pcau_pkg::POS_LAST) begin
                                n_unlocked   = 1'b1;
                                n_clock_bits = rot_wide[2*pcau_pkg::WORD_W-1:pcau_pkg::WORD_W];
                            end
                        end else begin
                            n_cmp_en = 1'b0;
                        end
                    end else begin
                        n_ring_pos = r_ring_pos + 1'b1;
                        if (r_ring_pos == pcau_pkg::POS_LAST) begin
                            n_unlocked = 1'b0;
                        end
                    end
                end
            end
            pcau_pkg::ACT_RESET: begin
                n_pat_pos  = '0;
                n_unlocked = 1'b0;
                n_cmp_en   = 1'b1;
            end
            default: begin
            end
        endcase

        n_result.data_out       = drive ? {i_data_in[pcau_pkg::DATA_W-1:1], clk_bit}
                                        : i_data_in;
        n_result.data_changed   = (i_action == pcau_pkg::ACT_WRITE) || drive;
        n_result.clock_unlocked = n_unlocked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= pcau_pkg::PATTERN_RESET;
            r_pat_pos    <= '0;
            r_ring_pos   <= '0;
            r_clock_bits <= '0;
            r_unlocked   <= 1'b0;
            r_cmp_en     <= 1'b1;
        end else begin
            if (cfg_write && paddr[3] == pcau_pkg::REG_MATCH_PATTERN) begin
                r_pattern <= pwdata;
            end
            if (accept_in) begin
                r_pat_pos    <= n_pat_pos;
                r_ring_pos   <= n_ring_pos;
                r_clock_bits <= n_clock_bits;
                r_unlocked   <= n_unlocked;
                r_cmp_en     <= n_cmp_en;
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept_in;
            end
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= n_result;
            end
        end else if (accept_in) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_out       = r_out.data_out;
    assign o_data_changed   = r_out.data_changed;
    assign o_clock_unlocked = r_out.clock_unlocked;

endmodule

`default_nettype wire

// File: rtl/core/pcau_checker.sv
// ----------------------------------------------------------------------------
// pcau_checker
// port-level checks of the phantom clock access and unlock block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pcau_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         o_in_ready,
    input  wire logic [pcau_pkg::ACT_W-1:0]   i_action,
    input  wire logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [pcau_pkg::DATA_W-1:0]  o_data_out,
    input  wire logic                         o_data_changed,
    input  wire logic                         o_clock_unlocked,
    input  wire logic                         pready
);

    logic rst_beat;

    assign rst_beat = i_in_valid && o_in_ready && (i_action == pcau_pkg::ACT_RESET);

    `ASSERT_CLK_ALL(a_pready_high, i_clk, pready, "pready low")

    `ASSERT_CLK_ALL(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready,
        "output stage not empty after reset")

    `ASSERT_CLK(a_stall_only_full, i_clk, i_rst_n, !o_in_ready |-> o_out_valid,
        "input stalled with empty output register")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_out)
            && $stable(o_data_changed) && $stable(o_clock_unlocked),
        "output beat changed while stalled")

    `ASSERT_CLK(a_reset_beat_locks, i_clk, i_rst_n,
        rst_beat && !o_out_valid |=> o_out_valid && !o_clock_unlocked && !o_data_changed,
        "device reset beat did not lock the clock")

endmodule

bind phantom_clock_access_unlock pcau_checker u_pcau_checker (.*);

`default_nettype wire
